FILE: design/mlr_pkg.sv
`timescale 1ns / 1ps

package mlr_pkg;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } mlr_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;    // capture ordered endpoints and intensity
      logic setup;   // derive deltas, decision term and increments
      logic step;    // emit current pixel and advance one point
   } mlr_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last;    // current point is the end point
   } mlr_sts_type;

endpackage

FILE: design/mlr_ctrl.sv
`timescale 1ns / 1ps

module mlr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output logic                rsp_last_pixel,
   output mlr_pkg::mlr_cmd_type cmd,
   input  mlr_pkg::mlr_sts_type sts
);
   import mlr_pkg::*;

   mlr_state_type state_ff;
   mlr_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (sts.last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      busy           = 1'b1;
      rsp_valid      = 1'b0;
      rsp_last_pixel = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_RUN: begin
            cmd.step       = 1'b1;
            rsp_valid      = 1'b1;
            rsp_last_pixel = sts.last;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

FILE: design/mlr_dp.sv
`timescale 1ns / 1ps

module mlr_dp #(
   parameter int COORD_BITS = 6
) (
   input  logic                  clock,
   input  mlr_pkg::mlr_cmd_type  cmd,
   output mlr_pkg::mlr_sts_type  sts,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic [15:0]           req_intensity,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [15:0]           rsp_pixel_value
);
   import mlr_pkg::*;

   // decision term needs |d| < 8 * 2^COORD_BITS
   localparam int DW = COORD_BITS + 4;

   logic [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [COORD_BITS-1:0] ax_in, ay_in, bx_in, by_in;
   logic [15:0]           val_ff, val_in;
   logic [COORD_BITS-1:0] x_ff, y_ff, x_in, y_in;
   logic [COORD_BITS-1:0] k_ff, k_in;
   logic [COORD_BITS-1:0] steps_ff, steps_in;
   logic                  steep_ff, steep_in;
   logic                  neg_ff, neg_in;
   logic signed [DW-1:0]  d_ff, d_in;
   logic signed [DW-1:0]  inc_minor_ff, inc_minor_in;
   logic signed [DW-1:0]  inc_both_ff, inc_both_in;

   // setup terms
   logic [COORD_BITS:0]   dx_full;
   logic [COORD_BITS:0]   adx_full;
   logic [COORD_BITS-1:0] adx, dy;
   logic signed [DW-1:0]  adx_s, dy_s;
   logic                  swap;
   logic                  take_both;
   logic [COORD_BITS-1:0] x_dir;

   assign swap      = req_start_y > req_end_y;
   assign dx_full   = {1'b0, bx_ff} - {1'b0, ax_ff};
   assign adx_full  = dx_full[COORD_BITS] ? (~dx_full + 1'b1) : dx_full;
   assign adx       = adx_full[COORD_BITS-1:0];
   assign dy        = by_ff - ay_ff;
   assign adx_s     = signed'({{(DW-COORD_BITS){1'b0}}, adx});
   assign dy_s      = signed'({{(DW-COORD_BITS){1'b0}}, dy});
   assign take_both = !(d_ff[DW-1] || (d_ff == '0));
   assign x_dir     = neg_ff ? (x_ff - 1'b1) : (x_ff + 1'b1);

   // Next values
   always_comb begin
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      val_in       = val_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      steps_in     = steps_ff;
      steep_in     = steep_ff;
      neg_in       = neg_ff;
      d_in         = d_ff;
      inc_minor_in = inc_minor_ff;
      inc_both_in  = inc_both_ff;
      if (cmd.load) begin
         // order endpoints so y does not fall
         ax_in  = swap ? req_end_x   : req_start_x;
         ay_in  = swap ? req_end_y   : req_start_y;
         bx_in  = swap ? req_start_x : req_end_x;
         by_in  = swap ? req_start_y : req_end_y;
         val_in = req_intensity;
      end
      if (cmd.setup) begin
         neg_in   = dx_full[COORD_BITS];
         steep_in = dy > adx;
         x_in     = ax_ff;
         y_in     = ay_ff;
         k_in     = '0;
         if (dy > adx) begin
            d_in         = (adx_s <<< 1) - dy_s;
            inc_minor_in = adx_s <<< 1;
            inc_both_in  = (adx_s - dy_s) <<< 1;
            steps_in     = dy;
         end else begin
            d_in         = (dy_s <<< 1) - adx_s;
            inc_minor_in = dy_s <<< 1;
            inc_both_in  = (dy_s - adx_s) <<< 1;
            steps_in     = adx;
         end
      end
      if (cmd.step) begin
         k_in = k_ff + 1'b1;
         if (take_both) begin
            d_in = d_ff + inc_both_ff;
            x_in = x_dir;
            y_in = y_ff + 1'b1;
         end else begin
            d_in = d_ff + inc_minor_ff;
            if (steep_ff) y_in = y_ff + 1'b1;
            else          x_in = x_dir;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      val_ff       <= val_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      k_ff         <= k_in;
      steps_ff     <= steps_in;
      steep_ff     <= steep_in;
      neg_ff       <= neg_in;
      d_ff         <= d_in;
      inc_minor_ff <= inc_minor_in;
      inc_both_ff  <= inc_both_in;
   end

   assign sts.last        = (k_ff == steps_ff);
   assign rsp_pixel_x     = x_ff;
   assign rsp_pixel_y     = y_ff;
   assign rsp_pixel_value = val_ff;

endmodule

FILE: design/midpoint_line_rasterizer.sv
`timescale 1ns / 1ps
// A command transfer moves the sequencer to a setup state with no pixel; the first
// pixel is strobed once it reaches the run state. A line of N = max(|dx|, dy) + 1
// pixels, at most 2^COORD_BITS, streams one pixel per cycle and holds busy through
// setup and run; a new command can be taken in the cycle after the last pixel.
// The pixel stepping loop makes one decision update per cycle.
// Reset (synchronous, active high) returns to idle and drops any line in flight.

module midpoint_line_rasterizer #(
   parameter int COORD_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic [15:0]           req_intensity,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [15:0]           rsp_pixel_value,
   output logic                  rsp_last_pixel
);
   import mlr_pkg::*;

   mlr_cmd_type cmd;
   mlr_sts_type sts;

   // Sequencer
   mlr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_last_pixel (rsp_last_pixel),
      .cmd            (cmd),
      .sts            (sts)
   );

   // Endpoint ordering and midpoint stepping
   mlr_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .sts             (sts),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_intensity   (req_intensity),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_value (rsp_pixel_value)
   );

`ifndef SYNTHESIS
   // A command transfer is followed by a setup cycle with no pixel
   a_setup_gap: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("pixel strobed in setup cycle");

   // Pixels only come out while a line is in progress
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("pixel strobed while idle");

   // Last pixel ends the line
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_pixel) |=> !busy)
      else $error("still busy after last pixel");

   // Within a line the next pixel follows, and its y stays or rises by one per step
   a_y_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_pixel) |=>
         (rsp_valid && ((rsp_pixel_y == $past(rsp_pixel_y)) ||
                        (rsp_pixel_y == $past(rsp_pixel_y) + 1'b1))))
      else $error("bad y step between pixels");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int COORD_BITS = 6;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      logic [15:0] value;
      logic        last;
   } raster_pixel_type;

   // Expected pixel stream: one entry per plotted point, oldest first
   class line_pixel_board_type;
      raster_pixel_type pending_pixels[$];
      int               mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // Walk the line the way the midpoint stepper does and queue each pixel
      function void plot_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                              logic [15:0] value);
         int               ax, ay, bx, by, swap_tmp;
         int               dx, dy, adx, step_x, decision;
         int               inc_minor, inc_both, steps, x, y;
         bit               steep;
         raster_pixel_type px;
         ax = sx;
         ay = sy;
         bx = ex;
         by = ey;
         // y must not fall from start to end
         if (ay > by) begin
            swap_tmp = ax; ax = bx; bx = swap_tmp;
            swap_tmp = ay; ay = by; by = swap_tmp;
         end
         dx     = bx - ax;
         dy     = by - ay;
         step_x = (dx < 0) ? -1 : 1;
         adx    = (dx < 0) ? -dx : dx;
         steep  = (dy > adx);
         if (steep) begin
            decision  = 2 * adx - dy;
            inc_minor = 2 * adx;
            inc_both  = 2 * (adx - dy);
            steps     = dy;
         end else begin
            decision  = 2 * dy - adx;
            inc_minor = 2 * dy;
            inc_both  = 2 * (dy - adx);
            steps     = adx;
         end
         x = ax;
         y = ay;
         for (int k = 0; k <= steps; k++) begin
            if (k > 0) begin
               if (decision <= 0) begin
                  decision += inc_minor;
                  if (steep)
                     y++;
                  else
                     x += step_x;
               end else begin
                  decision += inc_both;
                  x += step_x;
                  y++;
               end
            end
            px.x     = coord_type'(x);
            px.y     = coord_type'(y);
            px.value = value;
            px.last  = (k == steps);
            pending_pixels.push_back(px);
         end
      endfunction

      // Compare one strobed pixel against the oldest expected one
      function void match_pixel(raster_pixel_type got);
         raster_pixel_type want;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d value=%0h last=%0b",
                     $time, got.x, got.y, got.value, got.last);
            mismatch_count++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.x !== want.x) begin
            $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, got.x);
            mismatch_count++;
         end
         if (got.y !== want.y) begin
            $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, got.y);
            mismatch_count++;
         end
         if (got.value !== want.value) begin
            $display("%0t: pixel_value expected %0h actual %0h",
                     $time, want.value, got.value);
            mismatch_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_pixel expected %0b actual %0b",
                     $time, want.last, got.last);
            mismatch_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   coord_type   req_start_x;
   coord_type   req_start_y;
   coord_type   req_end_x;
   coord_type   req_end_y;
   logic [15:0] req_intensity;
   logic        rsp_valid;
   coord_type   rsp_pixel_x;
   coord_type   rsp_pixel_y;
   logic [15:0] rsp_pixel_value;
   logic        rsp_last_pixel;

   line_pixel_board_type board = new();

   midpoint_line_rasterizer #(
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_intensity  (req_intensity),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_last_pixel (rsp_last_pixel)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Pixel monitor: every strobed pixel is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.match_pixel({rsp_pixel_x, rsp_pixel_y, rsp_pixel_value, rsp_last_pixel});
   end

   // Hold a command until it transfers; junk on the fields while idling.
   // Called and returns at a falling edge.
   task automatic send_line(input coord_type sx, input coord_type sy, input coord_type ex,
                            input coord_type ey, input logic [15:0] value,
                            input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start         <= 1'b0;
         req_start_x   <= coord_type'($urandom);
         req_start_y   <= coord_type'($urandom);
         req_end_x     <= coord_type'($urandom);
         req_end_y     <= coord_type'($urandom);
         req_intensity <= 16'($urandom);
         @(negedge clock);
      end
      start         <= 1'b1;
      req_start_x   <= sx;
      req_start_y   <= sy;
      req_end_x     <= ex;
      req_end_y     <= ey;
      req_intensity <= value;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      board.plot_line(sx, sy, ex, ey, value);
      @(negedge clock);
   endtask

   // Mix of arbitrary, short, axis-aligned, diagonal and single-point lines
   task automatic random_lines(input int count, input int idle_pct);
      coord_type sx, sy, ex, ey;
      int        kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         sx   = coord_type'($urandom);
         sy   = coord_type'($urandom);
         ex   = coord_type'($urandom);
         ey   = coord_type'($urandom);
         if (kind < 15) begin
            ex = sx + coord_type'($urandom_range(0, 6)) - coord_type'(3);
            ey = sy + coord_type'($urandom_range(0, 6)) - coord_type'(3);
         end else if (kind < 20) begin
            ex = sx;
            ey = sy;
         end else if (kind < 25) begin
            ey = sy;
         end else if (kind < 30) begin
            ex = sx;
         end else if (kind < 35) begin
            ex = sx + (ey - sy);
         end
         send_line(sx, sy, ex, ey, 16'($urandom), idle_pct);
      end
   endtask

   // Main sequence
   initial begin
      int drain_cycles;
      reset         = 1'b1;
      start         = 1'b0;
      req_start_x   = '0;
      req_start_y   = '0;
      req_end_x     = '0;
      req_end_y     = '0;
      req_intensity = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: single points, axis lines, diagonals, octants, swaps
      send_line(6'd0,  6'd0,  6'd0,  6'd0,  16'h0000, 0);
      send_line(6'd63, 6'd63, 6'd63, 6'd63, 16'hFFFF, 0);
      send_line(6'd0,  6'd0,  6'd63, 6'd0,  16'hAAAA, 0);
      send_line(6'd63, 6'd5,  6'd0,  6'd5,  16'h5555, 0);
      send_line(6'd10, 6'd0,  6'd10, 6'd63, 16'h0001, 0);
      send_line(6'd10, 6'd63, 6'd10, 6'd0,  16'h8000, 0);
      send_line(6'd0,  6'd0,  6'd63, 6'd63, 16'hFFFF, 0);
      send_line(6'd63, 6'd0,  6'd0,  6'd63, 16'h0000, 0);
      send_line(6'd0,  6'd63, 6'd63, 6'd0,  16'h1234, 0);
      send_line(6'd2,  6'd3,  6'd40, 6'd17, 16'h00FF, 0);
      send_line(6'd50, 6'd4,  6'd1,  6'd20, 16'hFF00, 0);
      send_line(6'd5,  6'd1,  6'd20, 6'd55, 16'h0F0F, 0);
      send_line(6'd60, 6'd2,  6'd30, 6'd62, 16'hF0F0, 0);
      send_line(6'd40, 6'd17, 6'd2,  6'd3,  16'h7FFF, 0);
      send_line(6'd20, 6'd55, 6'd5,  6'd1,  16'hC3C3, 0);
      send_line(6'd7,  6'd9,  6'd8,  6'd9,  16'h3C3C, 0);
      send_line(6'd7,  6'd9,  6'd7,  6'd10, 16'h0002, 0);
      send_line(6'd7,  6'd9,  6'd8,  6'd10, 16'hFFFE, 0);
      send_line(6'd0,  6'd0,  6'd63, 6'd1,  16'hBEEF, 0);
      send_line(6'd0,  6'd0,  6'd1,  6'd63, 16'h4321, 0);

      // Random: back to back, then sender gaps at two rates
      random_lines(95, 0);
      random_lines(95, 46);
      random_lines(95, 24);

      start <= 1'b0;

      // Drain outstanding pixels, then watch for strays
      drain_cycles = 0;
      while (board.pending_pixels.size() != 0 && drain_cycles < 1000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (16) @(posedge clock);

      if (board.pending_pixels.size() != 0)
         $display("%0t: %0d expected pixels never arrived",
                  $time, board.pending_pixels.size());
      if (board.mismatch_count == 0 && board.pending_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
design/mlr_pkg.sv
design/mlr_ctrl.sv
design/mlr_dp.sv
design/midpoint_line_rasterizer.sv
sim/tb_top.sv
